>>> rtl/lcd_controller_serial_frame_writer_unit_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef LCD_CONTROLLER_SERIAL_FRAME_WRITER_UNIT_MACROS_SVH
`define LCD_CONTROLLER_SERIAL_FRAME_WRITER_UNIT_MACROS_SVH

`define LCDSW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcdsw assertion failed");

`define LCDSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcdsw assertion failed");

`endif

>>> rtl/lcdsw_pkg.sv
package lcdsw_pkg;

    localparam int C_MAX_BITS  = 10;
    localparam int C_ID_BITS   = 3;
    localparam int C_ADDR_BITS = 7;
    localparam int C_BYTE_BITS = 8;
    localparam int C_NIB_BITS  = 4;
    localparam int C_CNT_W     = $clog2(C_MAX_BITS + 1);

    localparam logic [C_ID_BITS-1:0] C_ID_CMD = 3'b100;
    localparam logic [C_ID_BITS-1:0] C_ID_WR  = 3'b101;

    typedef logic [C_CNT_W-1:0]    t_cnt;
    typedef logic [C_MAX_BITS-1:0] t_bits;

    typedef enum logic [1:0] {
        REQ_OPEN_CMD = 2'd0,
        REQ_OPEN_WR  = 2'd1,
        REQ_CMD      = 2'd2,
        REQ_DATA     = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_CMD  = 2'd1,
        FS_WR   = 2'd2
    } t_frame_state;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [C_ADDR_BITS-1:0] address;
        logic [C_BYTE_BITS-1:0] value;
        logic                   nibble_only;
        logic                   end_frame;
    } t_req;

    // bits are left aligned, MSB goes out first
    typedef struct packed {
        t_bits bits;
        t_cnt  cnt;
        logic  rel_cs;
        logic  err;
    } t_frame;

endpackage

>>> rtl/lcdsw_req_if.sv
interface lcdsw_req_if
    import lcdsw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             req_type;
    logic [C_ADDR_BITS-1:0] address;
    logic [C_BYTE_BITS-1:0] value;
    logic                   nibble_only;
    logic                   end_frame;

    modport source (
        output valid, req_type, address, value, nibble_only, end_frame,
        input  ready
    );
    modport sink (
        input  valid, req_type, address, value, nibble_only, end_frame,
        output ready
    );
endinterface

>>> rtl/lcdsw_res_if.sv
interface lcdsw_res_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic release_cs;
    logic status;
    logic last;

    modport source (
        output valid, data_bit, release_cs, status, last,
        input  ready
    );
    modport sink (
        input  valid, data_bit, release_cs, status, last,
        output ready
    );
endinterface

>>> rtl/lcdsw_frame_build.sv
module lcdsw_frame_build
    import lcdsw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcdsw_req_if.sink  i_req,
    input  logic       i_take,
    output logic       o_frame_valid,
    output t_frame     o_frame
);

    logic         r_in_valid;
    t_req         r_req;
    t_frame_state r_frame_state;
    t_frame_state n_frame_state;
    t_frame       n_frame;

    assign i_req.ready   = !r_in_valid || i_take;
    assign o_frame_valid = r_in_valid;
    assign o_frame       = n_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_frame_state <= FS_IDLE;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (i_take) begin
                r_frame_state <= n_frame_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= '{req_type:    i_req.req_type,
                       address:     i_req.address,
                       value:       i_req.value,
                       nibble_only: i_req.nibble_only,
                       end_frame:   i_req.end_frame};
        end
    end

    always_comb begin
        n_frame       = '0;
        n_frame_state = r_frame_state;
        unique case (r_req.req_type)
            REQ_OPEN_CMD: begin
                if (r_frame_state == FS_IDLE) begin
                    n_frame.bits  = {C_ID_CMD, (C_MAX_BITS - C_ID_BITS)'(0)};
                    n_frame.cnt   = t_cnt'(C_ID_BITS);
                    n_frame_state = FS_CMD;
                end else begin
                    n_frame.err = 1'b1;
                end
            end
            REQ_OPEN_WR: begin
                if (r_frame_state == FS_IDLE) begin
                    n_frame.bits  = {C_ID_WR, r_req.address};
                    n_frame.cnt   = t_cnt'(C_ID_BITS + C_ADDR_BITS);
                    n_frame_state = FS_WR;
                end else begin
                    n_frame.err = 1'b1;
                end
            end
            REQ_CMD: begin
                // trailing zero after the command byte
                if (r_frame_state == FS_CMD) begin
                    n_frame.bits = {r_req.value, (C_MAX_BITS - C_BYTE_BITS)'(0)};
                    n_frame.cnt  = t_cnt'(C_BYTE_BITS + 1);
                end else begin
                    n_frame.err = 1'b1;
                end
            end
            REQ_DATA: begin
                if (r_frame_state == FS_WR) begin
                    if (r_req.nibble_only) begin
                        n_frame.bits = {r_req.value[C_NIB_BITS-1:0],
                                        (C_MAX_BITS - C_NIB_BITS)'(0)};
                        n_frame.cnt  = t_cnt'(C_NIB_BITS);
                    end else begin
                        n_frame.bits = {r_req.value, (C_MAX_BITS - C_BYTE_BITS)'(0)};
                        n_frame.cnt  = t_cnt'(C_BYTE_BITS);
                    end
                end else begin
                    n_frame.err = 1'b1;
                end
            end
            default: begin
                n_frame.err = 1'b1;
            end
        endcase

        if (n_frame.err) begin
            // rejected request: one slot, state untouched
            n_frame.bits  = '0;
            n_frame.cnt   = t_cnt'(1);
            n_frame_state = r_frame_state;
        end else if (r_req.end_frame) begin
            n_frame.rel_cs = 1'b1;
            n_frame_state  = FS_IDLE;
        end
    end

endmodule

>>> rtl/lcdsw_shifter.sv
`include "lcd_controller_serial_frame_writer_unit_macros.svh"

module lcdsw_shifter
    import lcdsw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_frame_valid,
    input  t_frame       i_frame,
    output logic         o_take,
    lcdsw_res_if.source  o_res
);

    logic  r_valid;
    t_bits r_bits;
    t_cnt  r_cnt;
    logic  r_rel;
    logic  r_err;
    logic  w_last;

    assign w_last = (r_cnt == t_cnt'(1));
    assign o_take = i_frame_valid && (!r_valid || (o_res.ready && w_last));

    assign o_res.valid      = r_valid;
    assign o_res.data_bit   = r_bits[C_MAX_BITS-1];
    assign o_res.release_cs = r_rel && w_last;
    assign o_res.status     = r_err;
    assign o_res.last       = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready && w_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bits <= i_frame.bits;
            r_cnt  <= i_frame.cnt;
            r_rel  <= i_frame.rel_cs;
            r_err  <= i_frame.err;
        end else if (r_valid && o_res.ready && !w_last) begin
            r_bits <= {r_bits[C_MAX_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt - t_cnt'(1);
        end
    end

    `LCDSW_ASSERT_IMPL(a_err_one_slot, r_valid && r_err, w_last && !r_bits[C_MAX_BITS-1] && !r_rel)
    `LCDSW_ASSERT_IMPL(a_cnt_range, r_valid, r_cnt != '0 && r_cnt <= t_cnt'(C_MAX_BITS))
    `LCDSW_ASSERT_NEXT(a_mid_frame_step, r_valid && o_res.ready && !w_last, r_valid && r_cnt == t_cnt'($past(r_cnt) - t_cnt'(1)))

endmodule

>>> rtl/lcd_controller_serial_frame_writer_unit.sv
// Serial frame writer for a three-wire LCD segment controller. Each request
// yields one result per bit slot in send order: 3 slots to open a command
// frame, 10 to open a write frame (ID then 7-bit address), 9 for a command
// byte, 8 or 4 for data; a request that does not suit the open frame yields
// one result with status set. The bit shift register emits one slot per
// cycle while the sink is ready, and the next request loads in the cycle its
// predecessor's last slot is taken: sustained output is one bit slot per
// cycle with no gaps between requests. An accepted request is registered in
// the frame builder, then loaded into the shift register for its first slot;
// a further request can be accepted while the previous one is shifting out.
module lcd_controller_serial_frame_writer_unit
    import lcdsw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcdsw_req_if.sink    i_req,
    lcdsw_res_if.source  o_res
);

    logic   w_take;
    logic   w_frame_valid;
    t_frame w_frame;

    lcdsw_frame_build u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_take        (w_take),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    lcdsw_shifter u_shifter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_frame_valid),
        .i_frame       (w_frame),
        .o_take        (w_take),
        .o_res         (o_res)
    );

endmodule

>>> tb/lcd_controller_serial_frame_writer_unit_tb.sv
`timescale 1ns / 100ps

module lcd_controller_serial_frame_writer_unit_tb;
    import lcdsw_pkg::*;

    typedef struct packed {
        logic data_bit;
        logic release_cs;
        logic status;
        logic last;
    } t_slot;

    logic i_clk;
    logic i_rst_n;

    lcdsw_req_if req_ch();
    lcdsw_res_if res_ch();

    lcd_controller_serial_frame_writer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_slot        slots_q[$];
    t_frame_state frame_st;
    int           idle_pct;
    int           stall_pct;
    int           err_count;
    int           n_reqs;
    int           n_rejects;
    int           n_slots;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("lcd_controller_serial_frame_writer_unit regression: fail");
        $finish;
    end

    // expected bit slots for one accepted request; updates the frame state
    task automatic predict_slots(input t_req r);
        t_bits        bits;
        int           nbits;
        logic         ok;
        t_frame_state nxt;
        t_slot        s;
        ok    = 1'b1;
        nxt   = frame_st;
        bits  = '0;
        nbits = 0;
        case (t_req_type'(r.req_type))
            REQ_OPEN_CMD: begin
                ok    = (frame_st == FS_IDLE);
                bits  = {C_ID_CMD, 7'b0};
                nbits = C_ID_BITS;
                nxt   = FS_CMD;
            end
            REQ_OPEN_WR: begin
                ok    = (frame_st == FS_IDLE);
                bits  = {C_ID_WR, r.address};
                nbits = C_ID_BITS + C_ADDR_BITS;
                nxt   = FS_WR;
            end
            REQ_CMD: begin
                ok    = (frame_st == FS_CMD);
                bits  = {r.value, 2'b0};
                nbits = C_BYTE_BITS + 1;
            end
            default: begin
                ok = (frame_st == FS_WR);
                if (r.nibble_only) begin
                    bits  = {r.value[3:0], 6'b0};
                    nbits = C_NIB_BITS;
                end else begin
                    bits  = {r.value, 2'b0};
                    nbits = C_BYTE_BITS;
                end
            end
        endcase
        if (!ok) begin
            slots_q.push_back('{data_bit: 1'b0, release_cs: 1'b0, status: 1'b1, last: 1'b1});
            n_rejects++;
        end else begin
            for (int i = 0; i < nbits; i++) begin
                s.data_bit   = bits[C_MAX_BITS-1-i];
                s.status     = 1'b0;
                s.last       = (i == nbits - 1);
                s.release_cs = s.last && r.end_frame;
                slots_q.push_back(s);
            end
            frame_st = r.end_frame ? FS_IDLE : nxt;
        end
    endtask

    task automatic send_req(input t_req_type rt, input logic [C_ADDR_BITS-1:0] addr,
                            input logic [C_BYTE_BITS-1:0] val, input logic nib,
                            input logic endf);
        t_req r;
        r = '{req_type: rt, address: addr, value: val, nibble_only: nib, end_frame: endf};
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.address     <= addr;
        req_ch.value       <= val;
        req_ch.nibble_only <= nib;
        req_ch.end_frame   <= endf;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_slots(r);
        n_reqs++;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (slots_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : res_check
        t_slot want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_slots++;
            if (slots_q.size() == 0) begin
                $error("result with no request pending: data_bit %0b status %0b",
                       res_ch.data_bit, res_ch.status);
                err_count++;
            end else begin
                want = slots_q.pop_front();
                if (res_ch.data_bit !== want.data_bit) begin
                    $error("data_bit: expected %0b, got %0b", want.data_bit, res_ch.data_bit);
                    err_count++;
                end
                if (res_ch.release_cs !== want.release_cs) begin
                    $error("release_cs: expected %0b, got %0b",
                           want.release_cs, res_ch.release_cs);
                    err_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, res_ch.status);
                    err_count++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, res_ch.last);
                    err_count++;
                end
            end
        end
        res_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic test_command_frames();
        send_req(REQ_OPEN_CMD, 7'h7F, 8'hFF, 1'b1, 1'b0);
        send_req(REQ_CMD, 7'h7F, 8'hFF, 1'b1, 1'b0);
        send_req(REQ_CMD, 7'h00, 8'h00, 1'b0, 1'b0);
        send_req(REQ_CMD, 7'h55, 8'h5A, 1'b0, 1'b1);
        send_req(REQ_OPEN_CMD, 7'h00, 8'h00, 1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_write_frames();
        send_req(REQ_OPEN_WR, 7'h7F, 8'h00, 1'b0, 1'b0);
        send_req(REQ_DATA, 7'h00, 8'hFF, 1'b0, 1'b0);
        send_req(REQ_DATA, 7'h7F, 8'hF0, 1'b1, 1'b0);
        send_req(REQ_DATA, 7'h00, 8'h0F, 1'b1, 1'b0);
        send_req(REQ_DATA, 7'h2A, 8'h00, 1'b0, 1'b1);
        send_req(REQ_OPEN_WR, 7'h00, 8'hFF, 1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_rejected_requests();
        send_req(REQ_CMD, 7'h11, 8'hA5, 1'b0, 1'b0);
        send_req(REQ_DATA, 7'h22, 8'h5A, 1'b1, 1'b1);
        send_req(REQ_OPEN_CMD, 7'h00, 8'h00, 1'b0, 1'b0);
        send_req(REQ_OPEN_CMD, 7'h00, 8'h00, 1'b0, 1'b1);
        send_req(REQ_OPEN_WR, 7'h33, 8'h00, 1'b0, 1'b1);
        send_req(REQ_DATA, 7'h00, 8'hC3, 1'b0, 1'b1);
        send_req(REQ_CMD, 7'h00, 8'h81, 1'b0, 1'b1);
        send_req(REQ_OPEN_WR, 7'h2A, 8'h00, 1'b0, 1'b0);
        send_req(REQ_OPEN_CMD, 7'h00, 8'h00, 1'b0, 1'b1);
        send_req(REQ_OPEN_WR, 7'h01, 8'h00, 1'b0, 1'b1);
        send_req(REQ_CMD, 7'h00, 8'h3C, 1'b0, 1'b1);
        send_req(REQ_DATA, 7'h00, 8'h96, 1'b0, 1'b1);
        wait_drain();
    endtask

    // mostly well-formed frames driven off the predicted frame state, some noise
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        idle_pct  = src_pct;
        stall_pct = snk_pct;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 12) begin
                send_req(t_req_type'($urandom_range(3)), 7'($urandom_range(127)),
                         8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            end else begin
                case (frame_st)
                    FS_IDLE: send_req($urandom_range(1) ? REQ_OPEN_WR : REQ_OPEN_CMD,
                                      7'($urandom_range(127)), 8'($urandom_range(255)),
                                      1'($urandom_range(1)), 1'($urandom_range(9) == 0));
                    FS_CMD:  send_req(REQ_CMD, 7'($urandom_range(127)),
                                      8'($urandom_range(255)), 1'($urandom_range(1)),
                                      1'($urandom_range(4) == 0));
                    default: send_req(REQ_DATA, 7'($urandom_range(127)),
                                      8'($urandom_range(255)), 1'($urandom_range(1)),
                                      1'($urandom_range(5) == 0));
                endcase
            end
        end
        wait_drain();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        frame_st  = FS_IDLE;
        idle_pct  = 0;
        stall_pct = 0;
        err_count = 0;
        n_reqs    = 0;
        n_rejects = 0;
        n_slots   = 0;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_OPEN_CMD;
        req_ch.address     <= '0;
        req_ch.value       <= '0;
        req_ch.nibble_only <= 1'b0;
        req_ch.end_frame   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_command_frames();
        test_write_frames();
        test_rejected_requests();
        test_random_traffic(0, 0, 90);
        test_random_traffic(50, 0, 90);
        test_random_traffic(0, 50, 90);
        test_random_traffic(25, 25, 90);

        $display("covered %0d requests (%0d rejected), %0d bit slots checked",
                 n_reqs, n_rejects, n_slots);
        $display("command and write frames, nibble data, misplaced requests, idle/stall mixes");
        if (err_count == 0) begin
            $display("lcd_controller_serial_frame_writer_unit regression: pass");
        end else begin
            $display("lcd_controller_serial_frame_writer_unit regression: fail");
        end
        $finish;
    end

endmodule
